// ===== rtl/mlpr_pkg.sv =====
// Package for the multiplexed length-prefixed packet receiver.
// Holds item types, command and result codes and the port count.
// No dependencies.
`default_nettype none
package mlpr_pkg;

    localparam int unsigned PORT_COUNT = 8;
    localparam logic [7:0] TIMEOUT_RESET = 8'd10;
    localparam logic [7:0] IDLE_MAX = 8'd255;

    localparam logic [1:0] CMD_ACTIVITY = 2'd0;
    localparam logic [1:0] CMD_BYTE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_ABORT = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] port;
        logic       line_low;
        logic [7:0] data_byte;
        logic       tx_pending;
        logic [2:0] tx_port;
        logic       lock_active;
        logic [2:0] lock_port;
    } mlpr_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] out_port;
        logic [7:0] out_data;
        logic       last;
    } mlpr_out_t;

endpackage
`default_nettype wire

// ===== rtl/mlpr_core.sv =====
// Receiver state and per-item update: one item handled per accept.
// Holds the timeout register. Depends on mlpr_pkg.
`default_nettype none
module mlpr_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire mlpr_pkg::mlpr_in_t item,
    input  wire logic             cfg_we,
    input  wire logic [7:0]       cfg_data,
    output logic                  res_valid,
    output mlpr_pkg::mlpr_out_t   res
);
    import mlpr_pkg::*;

    logic       receiving_reg, receiving_next;
    logic       length_known_reg, length_known_next;
    logic [7:0] packet_length_reg, packet_length_next;
    logic [7:0] byte_index_reg, byte_index_next;
    logic [7:0] idle_ticks_reg, idle_ticks_next;
    logic [2:0] selected_port_reg, selected_port_next;
    logic [7:0] timeout_reg;

    logic [7:0] index_inc;
    logic [7:0] idle_inc;
    logic       port_ok;

    assign index_inc = byte_index_reg + 8'd1;
    assign idle_inc  = (idle_ticks_reg < IDLE_MAX) ? idle_ticks_reg + 8'd1 : idle_ticks_reg;
    assign port_ok   = 32'(item.port) < PORT_COUNT;

    always_comb
    begin
        receiving_next     = receiving_reg;
        length_known_next  = length_known_reg;
        packet_length_next = packet_length_reg;
        byte_index_next    = byte_index_reg;
        idle_ticks_next    = idle_ticks_reg;
        selected_port_next = selected_port_reg;
        res_valid          = 1'b0;
        res.kind           = KIND_DATA;
        res.out_data       = 8'd0;
        res.last           = 1'b0;
        case (item.cmd)
            CMD_ACTIVITY:
            begin
                if (!receiving_reg && item.line_low && port_ok
                    && !(item.tx_pending && item.port != item.tx_port)
                    && !(item.lock_active && item.port != selected_port_reg))
                begin
                    selected_port_next = item.port;
                    receiving_next     = 1'b1;
                    length_known_next  = 1'b0;
                    packet_length_next = 8'd0;
                    byte_index_next    = 8'd0;
                    idle_ticks_next    = 8'd0;
                    res_valid          = 1'b1;
                    res.kind           = KIND_START;
                end
            end
            CMD_BYTE:
            begin
                if (receiving_reg)
                begin
                    idle_ticks_next = 8'd0;
                    if (!length_known_reg)
                    begin
                        packet_length_next = item.data_byte;
                        length_known_next  = 1'b1;
                        byte_index_next    = 8'd0;
                        if (item.data_byte == 8'd0)
                        begin
                            receiving_next = 1'b0;
                            res_valid      = 1'b1;
                            res.kind       = KIND_EMPTY;
                        end
                    end
                    else
                    begin
                        byte_index_next = index_inc;
                        res_valid       = 1'b1;
                        res.kind        = KIND_DATA;
                        res.out_data    = item.data_byte;
                        if (index_inc >= packet_length_reg)
                        begin
                            receiving_next = 1'b0;
                            res.last       = 1'b1;
                        end
                    end
                end
            end
            CMD_TICK:
            begin
                if (receiving_reg)
                begin
                    idle_ticks_next = idle_inc;
                    if (idle_inc >= timeout_reg)
                    begin
                        receiving_next  = 1'b0;
                        idle_ticks_next = 8'd0;
                        res_valid       = 1'b1;
                        res.kind        = KIND_ABORT;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.out_port = selected_port_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg     <= 1'b0;
            length_known_reg  <= 1'b0;
            packet_length_reg <= 8'd0;
            byte_index_reg    <= 8'd0;
            idle_ticks_reg    <= 8'd0;
            selected_port_reg <= 3'd0;
            timeout_reg       <= TIMEOUT_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_data;
            end
            if (accept)
            begin
                receiving_reg     <= receiving_next;
                length_known_reg  <= length_known_next;
                packet_length_reg <= packet_length_next;
                byte_index_reg    <= byte_index_next;
                idle_ticks_reg    <= idle_ticks_next;
                selected_port_reg <= selected_port_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mlpr_out_buf.sv =====
// Two-entry result buffer: output register plus one skid slot.
// Depends on mlpr_pkg.
`default_nettype none
module mlpr_out_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire mlpr_pkg::mlpr_out_t din,
    output logic                    full,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output mlpr_pkg::mlpr_out_t     result
);
    import mlpr_pkg::*;

    mlpr_out_t  slot0_reg;
    mlpr_out_t  slot1_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign result_valid = count_reg != 2'd0;
    assign result       = slot0_reg;
    assign full         = count_reg == 2'd2;
    assign pop          = result_valid && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && pop)
        begin
            if (count_reg == 2'd1)
            begin
                slot0_reg <= din;
            end
            else
            begin
                slot0_reg <= slot1_reg;
                slot1_reg <= din;
            end
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_reg <= din;
            end
            else
            begin
                slot1_reg <= din;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/muxed_length_prefixed_packet_receiver.sv =====
// Multiplexed length-prefixed packet receiver, top level.
// Results are registered: each result passes through the output buffer before it appears on result.
// Throughput: one item per cycle; input stalls only when both result slots are full.
// Reset: asynchronous active low; idle, port 0, timeout 10 ticks, buffer empty.
// Depends on mlpr_pkg, mlpr_core, mlpr_out_buf.
`default_nettype none
module muxed_length_prefixed_packet_receiver (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire mlpr_pkg::mlpr_in_t  item,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output mlpr_pkg::mlpr_out_t      result,
    input  wire logic                cfg_we,
    input  wire logic [7:0]          cfg_data
);
    import mlpr_pkg::*;

    logic      accept;
    logic      res_valid;
    logic      full;
    mlpr_out_t res;

    assign item_stall = full;
    assign accept     = item_valid && !full;

    mlpr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    mlpr_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept && res_valid),
        .din          (res),
        .full         (full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire
